@@ src/tsb_pkg.sv @@
// Shared types, constants and coordinate helpers for the bilinear texture sampler.
// No dependencies; every other file of the block but tsb_ram imports this package.
`timescale 1ns / 1ps

package tsb_pkg;

   // Image and store geometry
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int DIM_W       = 9;                     // holds 1..256
   localparam int IDX_W       = 8;                     // texel column or row, 0..255
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Color and weights
   localparam int CHAN_W    = 16;
   localparam int NUM_CHAN  = 3;
   localparam int TEXEL_W   = NUM_CHAN * CHAN_W;
   localparam int WT_W      = 17;                      // Q.16 weight, 0..1.0
   localparam logic [WT_W-1:0] ONE_Q16 = 17'h10000;

   // Coordinate arithmetic
   localparam int PROD_W = 33;                         // coord * dimension, signed

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 4;

   // Action codes
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_FETCH  = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FILTER = 2'd2;

   // Filter modes
   localparam logic FILTER_NEAREST  = 1'b0;
   localparam logic FILTER_BILINEAR = 1'b1;

   // One queued operation: a texel write, or a four-texel read with blend weights
   typedef struct packed {
      logic                        is_wr;
      logic [3:0][ADDR_W-1:0]      addr;   // 00, 01, 10, 11 neighbors
      logic [WT_W-1:0]             wx;
      logic [WT_W-1:0]             wy;
      logic [TEXEL_W-1:0]          texel;
   } tsb_entry_type;

   // Neighbor pair and weight along one axis
   typedef struct packed {
      logic [IDX_W-1:0] i0;
      logic [IDX_W-1:0] i1;
      logic [WT_W-1:0]  wt;
   } tsb_axis_type;

   // Nearest texel along one axis: round half up, clamp to 0..dim-1
   function automatic logic [IDX_W-1:0] near_idx(input logic signed [PROD_W-1:0] p,
                                                 input logic [DIM_W-1:0] dim);
      logic signed [PROD_W:0] s;
      logic [16:0]            r;
      logic [16:0]            dm1;
      logic [IDX_W-1:0]       res;
      s   = {p[PROD_W-1], p} + (PROD_W+1)'(32768);
      r   = s[32:16];
      dm1 = {8'd0, dim} - 17'd1;
      if (p[PROD_W-1])
         res = '0;
      else if (r >= dm1)
         res = dm1[IDX_W-1:0];
      else
         res = r[IDX_W-1:0];
      return res;
   endfunction

   // Bilinear neighbors: floor(p - 0.5), both clamped; weight clamped to 0..1
   function automatic tsb_axis_type lerp_axis(input logic signed [PROD_W-1:0] p,
                                              input logic [DIM_W-1:0] dim);
      logic signed [PROD_W:0] f;
      logic signed [17:0]     fl;
      logic [DIM_W-1:0]       dm1;
      tsb_axis_type           res;
      f   = {p[PROD_W-1], p} - (PROD_W+1)'(32768);
      fl  = f[PROD_W:16];
      dm1 = dim - DIM_W'(1);
      if (fl[17]) begin
         res.i0 = '0;
         res.wt = '0;
      end else if (fl > $signed({9'd0, dm1})) begin
         res.i0 = dm1[IDX_W-1:0];
         res.wt = ONE_Q16;
      end else begin
         res.i0 = fl[IDX_W-1:0];
         res.wt = {1'b0, f[15:0]};
      end
      res.i1 = ({1'b0, res.i0} == dm1) ? res.i0 : res.i0 + IDX_W'(1);
      return res;
   endfunction

   // Integer coordinate clamped to 0..dim-1
   function automatic logic [IDX_W-1:0] clamp_coord(input logic signed [15:0] c,
                                                    input logic [DIM_W-1:0] dim);
      logic [DIM_W-1:0] dm1;
      logic [IDX_W-1:0] res;
      dm1 = dim - DIM_W'(1);
      if (c[15])
         res = '0;
      else if (c > $signed({7'd0, dm1}))
         res = dm1[IDX_W-1:0];
      else
         res = c[IDX_W-1:0];
      return res;
   endfunction

endpackage

@@ src/tsb_ram.sv @@
// Generic single-write, single-read RAM with registered, enabled read data.
// No dependencies.
`timescale 1ns / 1ps

module tsb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/tsb_front.sv @@
// Front part: accepts items, scales coordinates, picks neighbors and weights, forms addresses.
// Depends on tsb_pkg; feeds tsb_queue.
`timescale 1ns / 1ps

module tsb_front import tsb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_action,
   input  logic signed [15:0]       req_x_coord,
   input  logic signed [15:0]       req_y_coord,
   input  logic signed [23:0]       req_u_coord,
   input  logic signed [23:0]       req_v_coord,
   input  logic [CHAN_W-1:0]        req_red_in,
   input  logic [CHAN_W-1:0]        req_green_in,
   input  logic [CHAN_W-1:0]        req_blue_in,
   input  logic [DIM_W-1:0]         img_w,
   input  logic [DIM_W-1:0]         img_h,
   input  logic                     filter_mode,
   output logic                     push_valid,
   output tsb_entry_type            push_entry,
   input  logic                     queue_full
);

   // Stage A: captured item and scaled coordinates
   logic                       a_v_ff;
   logic [1:0]                 a_act_ff;
   logic signed [15:0]         a_x_ff, a_y_ff;
   logic signed [PROD_W-1:0]   a_pu_ff, a_pv_ff;
   logic [TEXEL_W-1:0]         a_texel_ff;
   logic signed [PROD_W:0]     pu_in, pv_in;

   // Stage B: neighbor indexes and weights
   logic                       b_v_ff, b_v_in;
   logic                       b_wr_ff, b_wr_in;
   logic [IDX_W-1:0]           b_x0_ff, b_x1_ff, b_y0_ff, b_y1_ff;
   logic [IDX_W-1:0]           b_x0_in, b_x1_in, b_y0_in, b_y1_in;
   logic [WT_W-1:0]            b_wx_ff, b_wy_ff, b_wx_in, b_wy_in;
   logic [TEXEL_W-1:0]         b_texel_ff;
   tsb_axis_type               ax, ay;

   // Stage C: queue entry with addresses
   logic                       c_v_ff;
   tsb_entry_type              c_ff, c_in;
   logic [16:0]                row0, row1;

   logic                       en_a, en_b, en_c;

   // Stage enables: a stage moves when empty or when the next one moves
   assign en_c      = !c_v_ff || !queue_full;
   assign en_b      = !b_v_ff || en_c;
   assign en_a      = !a_v_ff || en_b;
   assign req_stall = !en_a;

   // Coordinate times dimension, Q.16
   assign pu_in = req_u_coord * $signed({1'b0, img_w});
   assign pv_in = req_v_coord * $signed({1'b0, img_h});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en_a) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_act_ff   <= req_action;
         a_x_ff     <= req_x_coord;
         a_y_ff     <= req_y_coord;
         a_pu_ff    <= pu_in[PROD_W-1:0];
         a_pv_ff    <= pv_in[PROD_W-1:0];
         a_texel_ff <= {req_blue_in, req_green_in, req_red_in};
      end
   end

   // Classify the item and pick texel indexes
   assign ax = lerp_axis(a_pu_ff, img_w);
   assign ay = lerp_axis(a_pv_ff, img_h);

   always_comb begin
      b_v_in  = 1'b0;
      b_wr_in = 1'b0;
      b_x0_in = '0;
      b_x1_in = '0;
      b_y0_in = '0;
      b_y1_in = '0;
      b_wx_in = '0;
      b_wy_in = '0;
      unique case (a_act_ff)
         ACT_WRITE: begin
            // writes outside the image are dropped
            b_v_in  = a_v_ff && !a_x_ff[15] && !a_y_ff[15]
                      && (a_x_ff < $signed({7'd0, img_w}))
                      && (a_y_ff < $signed({7'd0, img_h}));
            b_wr_in = 1'b1;
            b_x0_in = a_x_ff[IDX_W-1:0];
            b_x1_in = a_x_ff[IDX_W-1:0];
            b_y0_in = a_y_ff[IDX_W-1:0];
            b_y1_in = a_y_ff[IDX_W-1:0];
         end
         ACT_FETCH: begin
            b_v_in  = a_v_ff;
            b_x0_in = clamp_coord(a_x_ff, img_w);
            b_x1_in = b_x0_in;
            b_y0_in = clamp_coord(a_y_ff, img_h);
            b_y1_in = b_y0_in;
         end
         ACT_SAMPLE: begin
            b_v_in = a_v_ff;
            if (filter_mode == FILTER_BILINEAR) begin
               b_x0_in = ax.i0;
               b_x1_in = ax.i1;
               b_y0_in = ay.i0;
               b_y1_in = ay.i1;
               b_wx_in = ax.wt;
               b_wy_in = ay.wt;
            end else begin
               // zero weights make the blend return the single texel
               b_x0_in = near_idx(a_pu_ff, img_w);
               b_x1_in = b_x0_in;
               b_y0_in = near_idx(a_pv_ff, img_h);
               b_y1_in = b_y0_in;
            end
         end
         default: begin
            b_v_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en_b) begin
         b_v_ff <= b_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_wr_ff    <= b_wr_in;
         b_x0_ff    <= b_x0_in;
         b_x1_ff    <= b_x1_in;
         b_y0_ff    <= b_y0_in;
         b_y1_ff    <= b_y1_in;
         b_wx_ff    <= b_wx_in;
         b_wy_ff    <= b_wy_in;
         b_texel_ff <= a_texel_ff;
      end
   end

   // Row-major addresses of the four neighbors
   assign row0 = {9'd0, b_y0_ff} * {8'd0, img_w};
   assign row1 = {9'd0, b_y1_ff} * {8'd0, img_w};

   always_comb begin
      c_in.is_wr   = b_wr_ff;
      c_in.addr[0] = ADDR_W'(row0 + {9'd0, b_x0_ff});
      c_in.addr[1] = ADDR_W'(row0 + {9'd0, b_x1_ff});
      c_in.addr[2] = ADDR_W'(row1 + {9'd0, b_x0_ff});
      c_in.addr[3] = ADDR_W'(row1 + {9'd0, b_x1_ff});
      c_in.wx      = b_wx_ff;
      c_in.wy      = b_wy_ff;
      c_in.texel   = b_texel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en_c) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_ff <= c_in;
      end
   end

   assign push_valid = c_v_ff;
   assign push_entry = c_ff;

endmodule

@@ src/tsb_queue.sv @@
// Short queue of operations between the front and back parts.
// Depends on tsb_pkg.
`timescale 1ns / 1ps

module tsb_queue import tsb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  tsb_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output tsb_entry_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tsb_entry_type    mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, rptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push       = push_valid && !full;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rptr_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
   end

   // The back part pops only what is there
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   // Count never runs past the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   // A lone push grows the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a push");

endmodule

@@ src/tsb_back.sv @@
// Back part: texel store in four copies, four-texel read, two-step blend, result register.
// Depends on tsb_pkg and tsb_ram; takes operations from tsb_queue.
`timescale 1ns / 1ps

module tsb_back import tsb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  tsb_entry_type      head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAN_W-1:0]  rsp_red_out,
   output logic [CHAN_W-1:0]  rsp_green_out,
   output logic [CHAN_W-1:0]  rsp_blue_out
);

   logic                 en_m1, en_m2, en_out;
   logic                 rd_go;
   logic [TEXEL_W-1:0]   q [4];

   // M1: texel reads in flight
   logic                 m1_v_ff;
   logic [WT_W-1:0]      m1_wx_ff, m1_wy_ff;
   logic [31:0]          a0_in [NUM_CHAN];
   logic [31:0]          a1_in [NUM_CHAN];

   // M2: horizontal blends
   logic                 m2_v_ff;
   logic [WT_W-1:0]      m2_wy_ff;
   logic [31:0]          m2_a0_ff [NUM_CHAN];
   logic [31:0]          m2_a1_ff [NUM_CHAN];
   logic [CHAN_W-1:0]    res_in [NUM_CHAN];

   // Result register
   logic                 out_v_ff;
   logic [CHAN_W-1:0]    out_ff [NUM_CHAN];

   assign en_out = !out_v_ff || !rsp_stall;
   assign en_m2  = !m2_v_ff || en_out;
   assign en_m1  = !m1_v_ff || en_m2;

   // Writes retire at the head; reads go when M1 can take them
   assign pop   = head_valid && (head.is_wr || en_m1);
   assign rd_go = pop && !head.is_wr;

   // Four copies of the store, one read port per neighbor
   for (genvar g = 0; g < 4; g++) begin : g_bank
      tsb_ram #(
         .WIDTH (TEXEL_W),
         .DEPTH (STORE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (pop && head.is_wr),
         .wr_addr (head.addr[0]),
         .wr_data (head.texel),
         .rd_en   (rd_go),
         .rd_addr (head.addr[g]),
         .rd_data (q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
      end else if (en_m1) begin
         m1_v_ff <= rd_go;
      end
   end

   always_ff @(posedge clock) begin
      if (en_m1) begin
         m1_wx_ff <= head.wx;
         m1_wy_ff <= head.wy;
      end
   end

   // Horizontal blend per channel, Q.16
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         a0_in[c] = 32'({17'd0, q[0][c*CHAN_W +: CHAN_W]} * {16'd0, ONE_Q16 - m1_wx_ff}
                      + {17'd0, q[1][c*CHAN_W +: CHAN_W]} * {16'd0, m1_wx_ff});
         a1_in[c] = 32'({17'd0, q[2][c*CHAN_W +: CHAN_W]} * {16'd0, ONE_Q16 - m1_wx_ff}
                      + {17'd0, q[3][c*CHAN_W +: CHAN_W]} * {16'd0, m1_wx_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_v_ff <= 1'b0;
      end else if (en_m2) begin
         m2_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_m2) begin
         m2_wy_ff <= m1_wy_ff;
         for (int c = 0; c < NUM_CHAN; c++) begin
            m2_a0_ff[c] <= a0_in[c];
            m2_a1_ff[c] <= a1_in[c];
         end
      end
   end

   // Vertical blend, Q.32, one rounding at the end
   always_comb begin
      logic [48:0] s;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s = {17'd0, m2_a0_ff[c]} * {32'd0, ONE_Q16 - m2_wy_ff}
           + {17'd0, m2_a1_ff[c]} * {32'd0, m2_wy_ff}
           + 49'h0_8000_0000;
         res_in[c] = s[47:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en_out) begin
         out_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            out_ff[c] <= res_in[c];
         end
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_red_out   = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_blue_out  = out_ff[2];

endmodule

@@ src/texture_sampler_bilinear_top.sv @@
// Top level of the bilinear texture sampler: register port, front, queue, back.
// Depends on tsb_pkg, tsb_front, tsb_queue, tsb_back (and tsb_ram below it).
//
//   channel   direction  handshake              beat
//   req_      in         req_valid / req_stall  action, x, y, u, v, color to write
//   rsp_      out        rsp_valid / rsp_stall  filtered or fetched color
//   register  in         psel/penable/pwrite    image_width, image_height, filter_mode
//
// One item per cycle sustained while rsp_stall stays low. A fetch or sample passes through
// three front stages, the queue, the store read, the blend stage and the result register.
// Four copies of the texel store let all four neighbors be read in the same cycle.
// Reset is synchronous; it clears control state, the store is not reset and keeps its contents.
// A stall on rsp_ backs up the back stages, then the queue, then req_stall.
`timescale 1ns / 1ps

module texture_sampler_bilinear_top import tsb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_x_coord,
   input  logic signed [15:0] req_y_coord,
   input  logic signed [23:0] req_u_coord,
   input  logic signed [23:0] req_v_coord,
   input  logic [15:0]        req_red_in,
   input  logic [15:0]        req_green_in,
   input  logic [15:0]        req_blue_in,
   // results
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_red_out,
   output logic [15:0]        rsp_green_out,
   output logic [15:0]        rsp_blue_out,
   // registers
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [DIM_W-1:0] width_ff, height_ff;
   logic             mode_ff;
   logic [DIM_W-1:0] img_w, img_h;
   logic             wr_go;
   logic [1:0]       reg_idx;

   logic             push_valid, queue_full, pop, head_valid;
   tsb_entry_type    push_entry, head;

   // Register port
   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_go   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(256);
         height_ff <= DIM_W'(256);
         mode_ff   <= FILTER_BILINEAR;
      end else if (wr_go) begin
         unique case (reg_idx)
            REG_WIDTH:  width_ff  <= pwdata[DIM_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[DIM_W-1:0];
            REG_FILTER: mode_ff   <= pwdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WIDTH:  prdata = {23'd0, width_ff};
         REG_HEIGHT: prdata = {23'd0, height_ff};
         REG_FILTER: prdata = {31'd0, mode_ff};
         default:    prdata = '0;
      endcase
   end

   // Effective image size: zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (width_ff == '0)
         img_w = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH))
         img_w = DIM_W'(MAX_WIDTH);
      else
         img_w = width_ff;
      if (height_ff == '0)
         img_h = DIM_W'(1);
      else if (height_ff > DIM_W'(MAX_HEIGHT))
         img_h = DIM_W'(MAX_HEIGHT);
      else
         img_h = height_ff;
   end

   tsb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_x_coord  (req_x_coord),
      .req_y_coord  (req_y_coord),
      .req_u_coord  (req_u_coord),
      .req_v_coord  (req_v_coord),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .img_w        (img_w),
      .img_h        (img_h),
      .filter_mode  (mode_ff),
      .push_valid   (push_valid),
      .push_entry   (push_entry),
      .queue_full   (queue_full)
   );

   tsb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   tsb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

endmodule
